[sv/sorted_set_table_unit_macros.svh]
// ----------------------------------------------------------------------------
// Sorted set table: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_UNIT_MACROS_SVH
`define SORTED_SET_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sst_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted set table: package
// Sizes, operation codes and status codes of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    // stream field widths
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCNT_W   = 7;
    localparam int IN_W     = 40;   // op + value, padded to bytes
    localparam int OUT_W    = 16;   // status + count + empty, padded to bytes

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;   // duplicate, absent or unused operation code
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

[sv/sorted_set_table_unit.sv]
// ----------------------------------------------------------------------------
// Sorted set table unit
// Set of distinct signed values kept sorted in a single-port-read table.
// ----------------------------------------------------------------------------
// Each input item adds, removes or looks up one value; each gives exactly one
// result item with a status, the element count after the operation and an
// empty flag. All work goes through one table read port and one compare unit,
// one entry a cycle: a linear scan for the value (stopping early on a match),
// then for an add a single ordering pass from the top entry down to entry 0,
// or for a remove a shift of the later entries down by one. The input is not
// ready while an item is in work; a finished result sits in an output
// register so the next item can be taken while it waits. No clearing pass is
// needed after reset: only entries below the count are ever read. The order
// register (descending when set) is taken on any cycle but should only change
// while the table is empty or idle; held entries are not re-sorted.
module sorted_set_table_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config: bit 0 descending_order
    input  logic                       i_cfg_valid,
    input  logic [0:0]                 i_cfg_data,
    output logic                       o_cfg_ready,
    // input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sst_pkg::IN_W-1:0]   s_axis_tdata,   // [1:0] op, [33:2] value
    // result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [sst_pkg::OUT_W-1:0]  m_axis_tdata    // [1:0] status,
                                                       // [8:2] element_count,
                                                       // [9] is_empty
);
    import sst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SORT     = 6'b000100,
        S_SORT_END = 6'b001000,
        S_SHIFT    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op, n_op;
    logic [VALUE_BITS-1:0]  r_value, n_value;
    logic [VALUE_BITS-1:0]  r_carry, n_carry;      // element travelling down
    logic [IDX_BITS-1:0]    r_idx, n_idx;
    logic [CNT_BITS-1:0]    r_count, n_count;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic                   r_desc;

    logic                   r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]    r_ostatus, n_ostatus;
    logic [OCNT_W-1:0]      r_ocount, n_ocount;
    logic                   r_oempty, n_oempty;

    // element table
    logic [VALUE_BITS-1:0]  r_mem [CAPACITY];
    logic [VALUE_BITS-1:0]  r_rdata;
    logic                   w_we;
    logic [IDX_BITS-1:0]    w_waddr;
    logic [VALUE_BITS-1:0]  w_wdata;
    logic [IDX_BITS-1:0]    w_raddr;

    // shared compare unit and index helpers
    logic                   w_cnt_zero;
    logic                   w_full;
    logic [CNT_BITS-1:0]    w_idx_inc;
    logic                   w_match;
    logic                   w_scan_last;
    logic                   w_before;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_oempty, r_ocount, r_ostatus};

    assign w_cnt_zero  = (r_count == '0);
    assign w_full      = (r_count == CNT_BITS'(CAPACITY));
    assign w_idx_inc   = CNT_BITS'(r_idx) + CNT_BITS'(1);
    assign w_match     = !w_cnt_zero && (r_rdata == r_value);
    assign w_scan_last = w_cnt_zero || (w_idx_inc == r_count);
    // carry goes before the entry below it under the current order
    assign w_before    = r_desc ? ($signed(r_carry) > $signed(r_rdata))
                                : ($signed(r_carry) < $signed(r_rdata));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_value   = r_value;
        n_carry   = r_carry;
        n_idx     = r_idx;
        n_count   = r_count;
        n_status  = r_status;
        n_ostatus = r_ostatus;
        n_ocount  = r_ocount;
        n_oempty  = r_oempty;
        n_ovalid  = r_ovalid && !m_axis_tready;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_rdata;
        w_raddr   = IDX_BITS'(w_idx_inc);

        unique case (r_state)
            S_IDLE: begin
                w_raddr = '0;   // entry 0 ready for the first scan cycle
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tdata[OP_W-1:0];
                    n_value = VALUE_BITS'(s_axis_tdata[OP_W +: VAL_W]);
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end

            // r_rdata holds entry r_idx
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_DONE;
                    unique case (r_op)
                        OP_ADD:    n_status = ST_MISS;
                        OP_REMOVE: begin
                            n_status = ST_OK;
                            if (w_idx_inc == r_count) begin
                                n_count = r_count - CNT_BITS'(1);
                            end else begin
                                n_state = S_SHIFT;   // read of r_idx+1 issued
                            end
                        end
                        OP_SEARCH: n_status = ST_OK;
                        default:   n_status = ST_MISS;
                    endcase
                end else if (w_scan_last) begin
                    n_state  = S_DONE;
                    n_status = ST_MISS;
                    if (r_op == OP_ADD) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else if (w_cnt_zero) begin
                            w_we     = 1'b1;
                            w_waddr  = '0;
                            w_wdata  = r_value;
                            n_count  = CNT_BITS'(1);
                            n_status = ST_OK;
                        end else begin
                            // new value enters at the top and travels down
                            n_carry = r_value;
                            n_idx   = IDX_BITS'(r_count);
                            w_raddr = IDX_BITS'(r_count - CNT_BITS'(1));
                            n_state = S_SORT;
                        end
                    end
                end else begin
                    n_idx = IDX_BITS'(w_idx_inc);
                end
            end

            // writes entry r_idx; r_rdata holds entry r_idx-1
            S_SORT: begin
                w_we = 1'b1;
                if (w_before) begin
                    w_wdata = r_rdata;
                end else begin
                    w_wdata = r_carry;
                    n_carry = r_rdata;
                end
                if (r_idx == IDX_BITS'(1)) begin
                    n_state = S_SORT_END;
                end else begin
                    n_idx   = r_idx - IDX_BITS'(1);
                    w_raddr = r_idx - IDX_BITS'(2);
                end
            end

            S_SORT_END: begin
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = r_carry;
                n_count  = r_count + CNT_BITS'(1);
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            // writes entry r_idx with entry r_idx+1
            S_SHIFT: begin
                w_we = 1'b1;
                if (CNT_BITS'(r_idx) + CNT_BITS'(2) == r_count) begin
                    n_count = r_count - CNT_BITS'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = IDX_BITS'(w_idx_inc);
                    w_raddr = r_idx + IDX_BITS'(2);
                end
            end

            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ocount  = OCNT_W'(r_count);
                    n_oempty  = w_cnt_zero;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_desc   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data[0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_value   <= n_value;
        r_carry   <= n_carry;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_ocount  <= n_ocount;
        r_oempty  <= n_oempty;
    end

    // table: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

endmodule

[sv/sst_checker.sv]
// ----------------------------------------------------------------------------
// Sorted set table: port checker
// Assertions on what the top level's ports show over time.
// ----------------------------------------------------------------------------
`include "sorted_set_table_unit_macros.svh"

module sst_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [sst_pkg::OUT_W-1:0]  m_axis_tdata
);
    import sst_pkg::*;

    logic w_in_acc;
    logic w_out_stall;
    logic w_empty_ok;
    logic w_status_ok;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_empty_ok  = (m_axis_tdata[9] == (m_axis_tdata[8:2] == 7'd0));
    assign w_status_ok = (m_axis_tdata[1:0] == ST_OK) || (m_axis_tdata[1:0] == ST_MISS)
                      || (m_axis_tdata[1:0] == ST_FULL);

    // a stalled result stays offered
    `SST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid, "result dropped")

    // empty flag agrees with the count
    `SST_ASSERT_IMP(a_empty, i_clk, i_rst_n, m_axis_tvalid, w_empty_ok, "empty flag vs count")

    // only defined status codes
    `SST_ASSERT_IMP(a_status, i_clk, i_rst_n, m_axis_tvalid, w_status_ok, "undefined status")

    // one item in work at a time
    `SST_ASSERT_NXT(a_busy, i_clk, i_rst_n, w_in_acc, !s_axis_tready, "ready after accept")

endmodule

bind sorted_set_table_unit sst_checker u_sst_checker (.*);

[test/sorted_set_table_checker.sv]
// ----------------------------------------------------------------------------
// Sorted set table: result checker
// Watches the order, input and result channels of the sorted set table,
// keeps its own copy of the table and compares every result item.
// ----------------------------------------------------------------------------
module sorted_set_table_checker
    import sst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [0:0]        i_cfg_data,
    input  logic              i_cfg_ready,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IN_W-1:0]   i_in_data,    // [1:0] op, [33:2] value
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [OUT_W-1:0]  i_out_data,   // [1:0] status, [8:2] count, [9] empty
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OCNT_W-1:0]   element_count;
        logic                is_empty;
    } set_result_t;

    // table copy: entries below held_total are live
    logic [VALUE_BITS-1:0] entries [CAPACITY];
    int                    held_total;
    logic                  descending;

    set_result_t           outcome_q [$];
    int                    mismatch_total;
    int                    result_no;

    assign o_fail_count = mismatch_total;

    initial begin
        mismatch_total = 0;
        result_no      = 0;
        held_total     = 0;
        descending     = 1'b0;
    end

    task automatic note_failure(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_total++;
    endtask

    // signed order under the current direction
    function automatic logic precedes(input logic [VALUE_BITS-1:0] a,
                                      input logic [VALUE_BITS-1:0] b);
        return descending ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    function automatic set_result_t apply_set_op(input logic [OP_W-1:0] op,
                                                 input logic [VAL_W-1:0] value);
        set_result_t           r;
        int                    pos;
        logic                  held;
        logic [VALUE_BITS-1:0] tmp;
        pos = held_total;
        for (int i = held_total - 1; i >= 0; i--) begin
            if (entries[i] == value) begin
                pos = i;
            end
        end
        held     = pos < held_total;
        r.status = ST_MISS;
        case (op)
            OP_ADD: begin
                if (held) begin
                    r.status = ST_MISS;
                end else if (held_total >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    entries[held_total] = value;
                    held_total++;
                    // one swap pass from the top entry down
                    for (int i = held_total - 1; i > 0; i--) begin
                        if (precedes(entries[i], entries[i-1])) begin
                            tmp          = entries[i];
                            entries[i]   = entries[i-1];
                            entries[i-1] = tmp;
                        end
                    end
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (held) begin
                    for (int i = pos; i + 1 < held_total; i++) begin
                        entries[i] = entries[i+1];
                    end
                    held_total--;
                    r.status = ST_OK;
                end
            end
            OP_SEARCH: begin
                r.status = held ? ST_OK : ST_MISS;
            end
            default: begin
                r.status = ST_MISS;
            end
        endcase
        r.element_count = OCNT_W'(held_total);
        r.is_empty      = (held_total == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        set_result_t want;
        set_result_t got;
        if (!i_rst_n) begin
            held_total = 0;
            descending = 1'b0;
            outcome_q.delete();
        end else begin
            // a result accepted now belongs to an earlier item
            if (i_out_valid && i_out_ready) begin
                got.status        = i_out_data[STATUS_W-1:0];
                got.element_count = i_out_data[STATUS_W +: OCNT_W];
                got.is_empty      = i_out_data[STATUS_W+OCNT_W];
                if (outcome_q.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with none outstanding",
                                           result_no));
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status)
                        note_failure($sformatf("result %0d status: want %0d got %0d",
                                               result_no, want.status, got.status));
                    if (got.element_count !== want.element_count)
                        note_failure($sformatf("result %0d count: want %0d got %0d",
                                               result_no, want.element_count,
                                               got.element_count));
                    if (got.is_empty !== want.is_empty)
                        note_failure($sformatf("result %0d empty flag: want %0d got %0d",
                                               result_no, want.is_empty, got.is_empty));
                end
                result_no++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                descending = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready) begin
                outcome_q.push_back(apply_set_op(i_in_data[OP_W-1:0],
                                                 i_in_data[OP_W +: VAL_W]));
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

[test/tb_sorted_set_table_unit.sv]
// ----------------------------------------------------------------------------
// Sorted set table unit: testbench
// Directed then random add, remove and search items under both orders, with
// random gaps on both streams; a checker beside the block predicts results.
// ----------------------------------------------------------------------------
module tb_sorted_set_table_unit;
    import sst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 150;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_N       = 72;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic [0:0]        i_cfg_data    = 1'b0;
    logic              o_cfg_ready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    int                fail_count;
    int                pending;
    int unsigned       cycle_count   = 0;
    int                src_idle_pct  = 0;
    int                snk_idle_pct  = 0;
    logic [VAL_W-1:0]  value_pool [POOL_N];

    sorted_set_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_set_table_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cfg_ready  (o_cfg_ready),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-OP_W-VAL_W){1'b0}}, value, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_order(input logic desc);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= desc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value;
        int r;
        r = $urandom_range(99);
        if (r < 75) return value_pool[$urandom_range(POOL_N-1)];
        if (r < 90) return $urandom;
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h8000_0001;
        endcase
    endfunction

    // filling: mostly adds; emptying: mostly removes
    function automatic logic [OP_W-1:0] pick_op(input logic filling);
        int r;
        r = $urandom_range(99);
        if (filling) begin
            if (r < 85) return OP_ADD;
            if (r < 90) return OP_REMOVE;
            if (r < 96) return OP_SEARCH;
            return OP_UNUSED;
        end
        if (r < 15) return OP_ADD;
        if (r < 70) return OP_REMOVE;
        if (r < 95) return OP_SEARCH;
        return OP_UNUSED;
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_idle_pct <= snk_pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_item(pick_op(k < (PHASE_ITEMS * 11) / 15), pick_value());
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_N; k++) value_pool[k] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_order(1'b0);
        // empty table, unused code, extremes, duplicate, hits and misses
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h0000_0005);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_ADD,    32'h0000_0000);
        send_item(OP_ADD,    32'h7FFF_FFFF);
        send_item(OP_ADD,    32'h8000_0000);
        send_item(OP_ADD,    32'hFFFF_FFFF);
        send_item(OP_ADD,    32'h0000_0001);
        send_item(OP_ADD,    32'h0000_0000);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h7FFF_FFFE);
        send_item(OP_REMOVE, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_REMOVE, 32'h7FFF_FFFF);
        send_item(OP_UNUSED, 32'h7FFF_FFFF);
        send_item(OP_ADD,    32'hAAAA_AAAA);
        send_item(OP_ADD,    32'h5555_5555);

        // flip the order with entries held: no re-sort, later adds use it
        set_order(1'b1);
        send_item(OP_ADD,    32'h0000_0002);
        send_item(OP_ADD,    32'hFFFF_FFFB);
        send_item(OP_SEARCH, 32'h0000_0001);
        send_item(OP_REMOVE, 32'h0000_0000);

        run_phase(29, 66);
        set_order(1'b0);
        run_phase(66, 29);
        set_order(1'b1);
        run_phase(0, 0);

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
